@@ src/dnfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfp_pkg
// Shared types and constants of the delimited number field parser.
// ----------------------------------------------------------------------------
package dnfp_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEX_MODE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS = 8'd1;

	localparam logic             HEX_MODE_RST   = 1'b1;
	localparam logic [INDEX_W-1:0] MAX_FIELDS_RST = 8'd6;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'ha;

	typedef struct packed {
		logic               sep;
		logic               digit_ok;
		logic [DIGIT_W-1:0] digit;
	} dec_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
		logic               field_valid;
		logic               done;
	} res_t;

endpackage

@@ src/dnfp_char_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfp_char_decode
// Classifies one character as separator or digit and gives its digit value.
// ----------------------------------------------------------------------------
module dnfp_char_decode import dnfp_pkg::*; (
	input  logic [CHAR_W-1:0] ch,
	input  logic              hex_mode,
	output dec_t              dec
);

	always_comb begin
		dec.sep      = (ch inside {CH_SPACE, CH_COLON, CH_COMMA});
		dec.digit_ok = 1'b0;
		dec.digit    = '0;
		if (ch inside {[CH_ZERO:CH_NINE]}) begin
			dec.digit_ok = 1'b1;
			dec.digit    = DIGIT_W'(ch - CH_ZERO);
		end else if (hex_mode && (ch inside {[CH_LA:CH_LF]})) begin
			dec.digit_ok = 1'b1;
			dec.digit    = DIGIT_W'(ch - CH_LA) + DIGIT_TEN;
		end else if (hex_mode && (ch inside {[CH_UA:CH_UF]})) begin
			dec.digit_ok = 1'b1;
			dec.digit    = DIGIT_W'(ch - CH_UA) + DIGIT_TEN;
		end
	end

endmodule

@@ src/dnfp_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfp_tokenizer
// Field state and accumulator; closes fields and forms at most one result per step.
// ----------------------------------------------------------------------------
module dnfp_tokenizer import dnfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dec_t               dec,
	input  logic               last,
	input  logic               hex_mode,
	input  logic [INDEX_W-1:0] max_fields,
	output res_t               res
);

	logic [VALUE_W-1:0] acc_q;
	logic               in_token_q;
	logic               stopped_q;
	logic [INDEX_W-1:0] fields_q;

	logic               start;
	logic               tok_now;
	logic               close;
	logic               emit;
	logic [VALUE_W-1:0] acc_base;
	logic [VALUE_W-1:0] acc_scaled;
	logic [VALUE_W-1:0] acc_n;
	logic               stopped_base;
	logic               stopped_n;

	always_comb begin
		start        = !dec.sep && !in_token_q;
		tok_now      = in_token_q || !dec.sep;
		acc_base     = start ? '0 : acc_q;
		stopped_base = start ? 1'b0 : stopped_q;
		acc_scaled   = hex_mode ? (acc_base << 4) : ((acc_base << 3) + (acc_base << 1));
		acc_n        = acc_base;
		stopped_n    = stopped_base;
		if (!dec.sep && !stopped_base) begin
			if (dec.digit_ok) begin
				acc_n = acc_scaled + VALUE_W'(dec.digit);
			end else begin
				stopped_n = 1'b1;
			end
		end
		close = (dec.sep || last) && tok_now;
		emit  = close && (fields_q < max_fields);

		res.valid       = emit || last;
		res.field_valid = emit;
		res.done        = last;
		res.index       = emit ? fields_q : '0;
		res.value       = '0;
		if (emit) begin
			res.value = hex_mode ? VALUE_W'(acc_n[7:0]) : acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			in_token_q <= 1'b0;
			stopped_q  <= 1'b0;
			fields_q   <= '0;
		end else if (step) begin
			if (last) begin
				acc_q      <= '0;
				in_token_q <= 1'b0;
				stopped_q  <= 1'b0;
				fields_q   <= '0;
			end else if (close) begin
				acc_q      <= '0;
				in_token_q <= 1'b0;
				stopped_q  <= 1'b0;
				fields_q   <= fields_q + INDEX_W'(emit);
			end else begin
				acc_q      <= acc_n;
				in_token_q <= tok_now;
				stopped_q  <= stopped_n;
			end
		end
	end

endmodule

@@ src/delimited_number_field_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_number_field_parser_core
// Parses separated hex or decimal fields of a character stream into numbers.
// ----------------------------------------------------------------------------
// An accepted character passes the input register, then the result register.
// Throughput: one character per cycle while the output is not stalled, set
// by the single accumulate step between the two registers.
// Reset: arst_n clears the field state and the pipeline valid flags at once;
// hex_mode returns to 1 and max_fields to 6.
module delimited_number_field_parser_core import dnfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // ch[7:0]
	input  logic                 s_tlast,   // end_of_text
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // value[31:0], field_index[39:32]
	output logic [0:0]           m_tuser,   // field_valid[0]
	output logic                 m_tlast,   // string_done
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic               hex_mode_q;
	logic [INDEX_W-1:0] max_fields_q;

	logic               valid_s1;
	logic [CHAR_W-1:0]  ch_s1;
	logic               last_s1;

	logic               out_valid_q;
	res_t               out_q;

	logic               can_adv;
	logic               step;
	dec_t               dec;
	res_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q   <= HEX_MODE_RST;
			max_fields_q <= MAX_FIELDS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_HEX_MODE) begin
				hex_mode_q <= cfg_data[0];
			end else if (cfg_index == REG_MAX_FIELDS) begin
				max_fields_q <= cfg_data;
			end
		end
	end

	assign can_adv  = !out_valid_q || m_tready;
	assign step     = valid_s1 && can_adv;
	assign s_tready = !valid_s1 || can_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dnfp_char_decode u_decode (
		.ch       (ch_s1),
		.hex_mode (hex_mode_q),
		.dec      (dec)
	);

	dnfp_tokenizer u_tokenizer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.dec        (dec),
		.last       (last_s1),
		.hex_mode   (hex_mode_q),
		.max_fields (max_fields_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_adv) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.index, out_q.value};
	assign m_tuser  = out_q.field_valid;
	assign m_tlast  = out_q.done;

`ifndef SYNTHESIS
	// A result that does not end the string always carries a field.
	a_mid_result_has_field: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> m_tuser[0])
		else $error("non-final result without a field");

	// A result without a field shows zero value and index.
	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("empty result carries data");

	// In hex mode a field value fits in a byte.
	a_hex_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && hex_mode_q) |-> (m_tdata[31:8] == '0))
		else $error("hex value wider than a byte");

	// A character held back by a full output stays in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_adv) |=> (valid_s1 && $stable(ch_s1) && $stable(last_s1)))
		else $error("stalled character lost");
`endif

endmodule
